/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked around reset.
`define SPF_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/spf_pkg.sv */
`default_nettype none
package spf_pkg;

    localparam int SMP_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 19;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    // Register indexes.
    localparam t_cfg_idx CFG_PHASER_STEP  = 3'd0;
    localparam t_cfg_idx CFG_PHASER_DEPTH = 3'd1;
    localparam t_cfg_idx CFG_FLANGE_STEP  = 3'd2;
    localparam t_cfg_idx CFG_FLANGE_DEPTH = 3'd3;
    localparam t_cfg_idx CFG_ECHO_DELAY   = 3'd4;
    localparam t_cfg_idx CFG_FEEDBACK     = 3'd5;
    localparam t_cfg_idx CFG_MIX          = 3'd6;

    // Horner coefficients of the quarter-wave sine series.
    localparam logic [17:0] SIN_C0 = 18'd307;
    localparam logic [17:0] SIN_C1 = 18'd5223;
    localparam logic [17:0] SIN_C2 = 18'd42334;
    localparam logic [17:0] SIN_C3 = 18'd102944;
    localparam logic [14:0] SIN_MAX = 15'd32767;

    localparam logic signed [18:0] UNITY    = 19'sd65536;
    localparam logic signed [17:0] HALF     = 18'sd32768;
    localparam logic signed [18:0] PH_SCALE = 19'sd13107;

    localparam logic signed [47:0] SMP_MAX = 48'sd8388607;
    localparam logic signed [47:0] SMP_MIN = -48'sd8388608;

    function automatic t_smp sat24(input logic signed [47:0] v);
        t_smp r;
        if (v > SMP_MAX) begin
            r = t_smp'(SMP_MAX);
        end else if (v < SMP_MIN) begin
            r = t_smp'(SMP_MIN);
        end else begin
            r = t_smp'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/stereo_phaser_flanger_delay.sv */
// The 35-step sequence around the single shared multiplier takes one input beat at a time,
// and a result that is not taken holds the last step.
// Reset (synchronous, active low) clears the LFO phases, write index and registers,
// then the delay memory is cleared word by word, during which no beat is taken.
// Configuration writes are accepted at any time, including the clearing pass.
`default_nettype none
module stereo_phaser_flanger_delay #(
    parameter int DELAY_DEPTH  = 131072,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  spf_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [spf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  spf_pkg::t_smp                       i_left_in,
    input  spf_pkg::t_smp                       i_right_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output spf_pkg::t_smp                       o_left_out,
    output spf_pkg::t_smp                       o_right_out
);
    import spf_pkg::*;

    // Address width of the delay memory, width of the sine index (the table size is a
    // power of two, so the index is the top bits of the phase), and a compare width that
    // holds both the echo register and any value below twice the memory depth.
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int SL = $clog2(SINE_ENTRIES);
    localparam int CW = ((AW > 17) ? AW : 17) + 1;
    localparam int RW = 2 * SMP_W;

    // The sequencer walks through one state per multiplier issue. The sine of each LFO is
    // evaluated on the fly with the same multiplier, so no table storage is needed: the
    // phaser sine is worked out first, then the flanger sine. The product of the operation
    // issued in one state is read in the next.
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_SQ, S_P1, S_P2, S_P3, S_P4, S_SIN,
        S_PH1, S_PH2, S_PH3, S_PH4, S_PH5,
        S_FL1, S_FL2, S_FL3, S_FL4,
        S_EC1, S_EC2, S_EC3, S_EC4, S_EC5, S_EC6, S_EC7, S_EC8,
        S_MX1, S_MX2, S_MX3, S_MX4
    } t_state;

    // Configuration registers.
    logic [31:0] r_ph_step;
    logic [16:0] r_ph_depth;
    logic [31:0] r_fl_step;
    logic [9:0]  r_fl_depth;
    logic [16:0] r_echo_dly;
    logic [16:0] r_fb;
    logic [16:0] r_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_step  <= '0;
            r_ph_depth <= '0;
            r_fl_step  <= '0;
            r_fl_depth <= '0;
            r_echo_dly <= '0;
            r_fb       <= '0;
            r_mix      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASER_STEP:  r_ph_step  <= i_cfg_data;
                CFG_PHASER_DEPTH: r_ph_depth <= i_cfg_data[16:0];
                CFG_FLANGE_STEP:  r_fl_step  <= i_cfg_data;
                CFG_FLANGE_DEPTH: r_fl_depth <= i_cfg_data[9:0];
                CFG_ECHO_DELAY:   r_echo_dly <= i_cfg_data[16:0];
                CFG_FEEDBACK:     r_fb       <= i_cfg_data[16:0];
                CFG_MIX:          r_mix      <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and datapath registers.
    t_state          r_state;
    logic [AW-1:0]   r_clr;
    logic [AW-1:0]   r_wi;
    logic [31:0]     r_ph_phase;
    logic [31:0]     r_fl_phase;
    logic            r_sel;
    logic [1:0]      r_quad;
    logic [16:0]     r_t;
    logic [16:0]     r_t2;
    logic signed [15:0] r_sin;
    logic signed [18:0] r_gain;
    t_smp            r_dry0, r_dry1;
    t_smp            r_w0, r_w1;
    t_smp            r_tap0, r_tap1;
    t_smp            r_e0, r_e1;
    t_smp            r_s0;
    t_smp            r_m0;
    logic signed [MUL_P_W-1:0] r_acc;
    logic            r_out_valid;
    t_smp            r_out0, r_out1;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    spf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Delay memory: left sample in the low half of each word, right in the high half.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    spf_ram #(
        .WIDTH (RW),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read address a given distance behind the write index, with the distance clamped to
    // one less than the memory depth and the result wrapped around the end of the memory.
    function automatic logic [AW-1:0] tap_addr(input logic [CW-1:0] span,
                                               input logic [AW-1:0] wi);
        logic [CW-1:0] lim;
        logic [CW-1:0] d;
        logic [CW-1:0] base;
        lim  = CW'(DELAY_DEPTH - 1);
        d    = (span > lim) ? lim : span;
        base = CW'(wi);
        if (base >= d) begin
            return AW'(base - d);
        end
        return AW'(base + CW'(DELAY_DEPTH) - d);
    endfunction

    // Combinational helpers around the product register.
    logic [31:0]        sel_phase;
    logic [17:0]        sin_pos;
    logic [16:0]        n_t;
    logic [16:0]        n_t2;
    logic [17:0]        prod_hi;
    logic [16:0]        sin_raw;
    logic [14:0]        sin_mag;
    logic signed [15:0] n_sin;
    logic signed [17:0] n_ph;
    logic signed [18:0] n_gain;
    logic signed [16:0] n_fl_mod;
    logic [11:0]        n_off;
    logic signed [47:0] p48;
    logic signed [47:0] sum48;
    t_smp               n_single;
    t_smp               n_mac;
    t_smp               n_fl0, n_fl1;
    t_smp               n_slot;
    t_smp               slot_base;
    logic signed [18:0] nfb, nmx, fb_s, mx_s;

    assign sel_phase = r_sel ? r_fl_phase : r_ph_phase;
    assign sin_pos   = 18'(sel_phase[31 -: SL]) << (18 - SL);
    assign n_t       = sin_pos[16] ? (17'd65536 - {1'b0, sin_pos[15:0]})
                                   : {1'b0, sin_pos[15:0]};
    assign prod_hi   = prod[33:16];
    assign n_t2      = prod[32:16];
    assign sin_raw   = prod[33:17];
    assign sin_mag   = (sin_raw > 17'(SIN_MAX)) ? SIN_MAX : sin_raw[14:0];
    assign n_sin     = r_quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign n_ph      = HALF + $signed(prod[33:16]);
    assign n_gain    = UNITY - $signed({prod[33], prod[33:16]});
    assign n_fl_mod  = 17'sd32768 + 17'(r_sin);
    assign n_off     = 12'(prod[26:15]) + 12'd1;
    assign p48       = 48'(prod);
    assign sum48     = 48'(r_acc) + p48;
    assign n_single  = sat24(p48 >>> 16);
    assign n_mac     = sat24(sum48 >>> 16);
    assign n_fl0     = sat24((48'(r_w0) + 48'($signed(ram_rdata[SMP_W-1:0]))) >>> 1);
    assign n_fl1     = sat24((48'(r_w1) + 48'($signed(ram_rdata[RW-1:SMP_W]))) >>> 1);
    assign slot_base = (r_state == S_EC8) ? r_w1 : r_w0;
    assign n_slot    = sat24(48'(slot_base) + (p48 >>> 16));
    assign fb_s      = $signed({2'b00, r_fb});
    assign mx_s      = $signed({2'b00, r_mix});
    assign nfb       = UNITY - fb_s;
    assign nmx       = UNITY - mx_s;

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = MUL_A_W'(r_t);
                mul_b = MUL_B_W'(r_t);
            end
            S_P1: begin
                mul_a = MUL_A_W'(SIN_C0);
                mul_b = MUL_B_W'(n_t2);
            end
            S_P2: begin
                mul_a = MUL_A_W'(SIN_C1 - prod_hi);
                mul_b = MUL_B_W'(r_t2);
            end
            S_P3: begin
                mul_a = MUL_A_W'(SIN_C2 - prod_hi);
                mul_b = MUL_B_W'(r_t2);
            end
            S_P4: begin
                mul_a = MUL_A_W'(SIN_C3 - prod_hi);
                mul_b = MUL_B_W'(r_t);
            end
            S_PH1: begin
                mul_a = MUL_A_W'(r_sin);
                mul_b = MUL_B_W'(r_ph_depth);
            end
            S_PH2: begin
                mul_a = MUL_A_W'(n_ph);
                mul_b = PH_SCALE;
            end
            S_PH3: begin
                mul_a = MUL_A_W'(r_dry0);
                mul_b = n_gain;
            end
            S_PH4: begin
                mul_a = MUL_A_W'(r_dry1);
                mul_b = r_gain;
            end
            S_FL1: begin
                mul_a = MUL_A_W'(n_fl_mod);
                mul_b = MUL_B_W'(r_fl_depth);
            end
            S_EC2: begin
                mul_a = MUL_A_W'(r_w0);
                mul_b = nfb;
            end
            S_EC3: begin
                mul_a = MUL_A_W'(r_tap0);
                mul_b = fb_s;
            end
            S_EC4: begin
                mul_a = MUL_A_W'(r_w1);
                mul_b = nfb;
            end
            S_EC5: begin
                mul_a = MUL_A_W'(r_tap1);
                mul_b = fb_s;
            end
            S_EC6: begin
                mul_a = MUL_A_W'(r_e0);
                mul_b = fb_s;
            end
            S_EC7: begin
                mul_a = MUL_A_W'(r_e1);
                mul_b = fb_s;
            end
            S_EC8: begin
                mul_a = MUL_A_W'(r_dry0);
                mul_b = nmx;
            end
            S_MX1: begin
                mul_a = MUL_A_W'(r_e0);
                mul_b = mx_s;
            end
            S_MX2: begin
                mul_a = MUL_A_W'(r_dry1);
                mul_b = nmx;
            end
            S_MX3, S_MX4: begin
                // Held in the last state too, so a stalled result keeps its product.
                mul_a = MUL_A_W'(r_e1);
                mul_b = mx_s;
            end
            default: ;
        endcase
    end

    // Delay memory port selection. The clearing pass writes zeros; the flanger result is
    // written first and the echo feedback term is added into the same slot later on.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wi;
        ram_wdata = {r_w1, r_w0};
        ram_raddr = tap_addr(CW'(r_echo_dly), r_wi);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_FL2: begin
                ram_raddr = tap_addr(CW'(n_off), r_wi);
            end
            S_FL4: begin
                ram_we = 1'b1;
            end
            S_EC8: begin
                ram_we    = 1'b1;
                ram_wdata = {n_slot, r_s0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wi        <= '0;
            r_ph_phase  <= '0;
            r_fl_phase  <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the last state the output register is reloaded below instead.
            if (r_out_valid && i_out_ready && (r_state != S_MX4)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DELAY_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dry0     <= i_left_in;
                        r_dry1     <= i_right_in;
                        r_ph_phase <= r_ph_phase + r_ph_step;
                        r_fl_phase <= r_fl_phase + r_fl_step;
                        r_sel      <= 1'b0;
                        r_state    <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_quad  <= sin_pos[17:16];
                    r_t     <= n_t;
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_P1;
                S_P1: begin
                    r_t2    <= n_t2;
                    r_state <= S_P2;
                end
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_P4;
                S_P4: r_state <= S_SIN;
                S_SIN: begin
                    r_sin   <= n_sin;
                    r_state <= r_sel ? S_FL1 : S_PH1;
                end
                S_PH1: r_state <= S_PH2;
                S_PH2: r_state <= S_PH3;
                S_PH3: begin
                    r_gain  <= n_gain;
                    r_state <= S_PH4;
                end
                S_PH4: begin
                    r_w0    <= n_single;
                    r_state <= S_PH5;
                end
                S_PH5: begin
                    r_w1    <= n_single;
                    r_sel   <= 1'b1;
                    r_state <= S_SETUP;
                end
                S_FL1: r_state <= S_FL2;
                S_FL2: r_state <= S_FL3;
                S_FL3: begin
                    r_w0    <= n_fl0;
                    r_w1    <= n_fl1;
                    r_state <= S_FL4;
                end
                S_FL4: r_state <= S_EC1;
                S_EC1: r_state <= S_EC2;
                S_EC2: begin
                    r_tap0  <= ram_rdata[SMP_W-1:0];
                    r_tap1  <= ram_rdata[RW-1:SMP_W];
                    r_state <= S_EC3;
                end
                S_EC3: begin
                    r_acc   <= prod;
                    r_state <= S_EC4;
                end
                S_EC4: begin
                    r_e0    <= n_mac;
                    r_state <= S_EC5;
                end
                S_EC5: begin
                    r_acc   <= prod;
                    r_state <= S_EC6;
                end
                S_EC6: begin
                    r_e1    <= n_mac;
                    r_state <= S_EC7;
                end
                S_EC7: begin
                    r_s0    <= n_slot;
                    r_state <= S_EC8;
                end
                S_EC8: begin
                    r_wi    <= (r_wi == AW'(DELAY_DEPTH - 1)) ? '0 : r_wi + 1'b1;
                    r_state <= S_MX1;
                end
                S_MX1: begin
                    r_acc   <= prod;
                    r_state <= S_MX2;
                end
                S_MX2: begin
                    r_m0    <= n_mac;
                    r_state <= S_MX3;
                end
                S_MX3: begin
                    r_acc   <= prod;
                    r_state <= S_MX4;
                end
                S_MX4: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out0      <= r_m0;
                        r_out1      <= n_mac;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out0;
    assign o_right_out = r_out1;

endmodule
`default_nettype wire

/* hdl/spf_ram.sv */
`default_nettype none
module spf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/spf_mul.sv */
`default_nettype none
module spf_mul (
    input  logic                                i_clk,
    input  logic signed [spf_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [spf_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [spf_pkg::MUL_P_W-1:0]  o_prod
);
    import spf_pkg::*;

    // Signed multiplier with its product registered.
    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end
endmodule
`default_nettype wire

/* hdl/spf_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module spf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input spf_pkg::t_smp                   o_left_out,
    input spf_pkg::t_smp                   o_right_out
);
    import spf_pkg::*;

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // The block works on one beat at a time.
    `SPF_ASSERT(a_busy_after_beat, i_clk, i_rst_n, in_beat |=> !o_in_ready,
        "input ready stayed high after a beat")

    // A result cannot appear the cycle after its beat is taken.
    `SPF_ASSERT(a_no_instant_result, i_clk, i_rst_n, in_beat |=> !$rose(o_out_valid),
        "result appeared too early")

    // A stalled result holds.
    `SPF_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_left_out) && $stable(o_right_out),
        "stalled result changed")

    // Straight out of reset the memory is being cleared and nothing is pending.
    `SPF_ASSERT_NR(a_reset_idle, i_clk, $rose(i_rst_n) |-> !o_in_ready && !o_out_valid,
        "block not quiet after reset")

endmodule

bind stereo_phaser_flanger_delay spf_checker u_spf_checker (.*);
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
    import spf_pkg::*;

    localparam int DEPTH   = 131072;
    localparam int SINE_N  = 1024;
    localparam int LATENCY = 40;
    // The watchdog must cover the memory-clearing pass after reset several times over,
    // and with it the long receiver hold-off used by the pressure test.
    localparam int STALL_LIMIT = 4 * DEPTH;
    // A register index beyond the last register, whose writes are ignored.
    localparam t_cfg_idx CFG_BAD_IDX = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_PHASER_STEP;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_smp        i_left_in = '0;
    t_smp        i_right_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_smp        o_left_out;
    t_smp        o_right_out;

    stereo_phaser_flanger_delay DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the effect: registers, LFO phases and the delay line.
    logic [31:0] sh_phaser_step, sh_flange_step, sh_phaser_phase, sh_flange_phase;
    logic [16:0] sh_phaser_depth, sh_echo_delay, sh_feedback, sh_mix;
    logic [9:0]  sh_flange_depth;
    logic [16:0] sh_wr_idx;
    int          sine_lut [SINE_N];
    int          line_l [DEPTH];
    int          line_r [DEPTH];

    // Expected output pairs, oldest first.
    t_smp exp_left_q[$];
    t_smp exp_right_q[$];

    int  n_errors = 0;
    int  n_sent = 0;
    int  n_recv = 0;
    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    bit  hold_recv = 1'b0;
    int  idle_cycles = 0;

    function automatic longint fl_shr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic int quarter_wave(longint unsigned t);
        longint unsigned t2, p, s;
        t2 = (t * t) >> 16;
        p  = 5223 - ((307 * t2) >> 16);
        p  = 42334 - ((p * t2) >> 16);
        p  = 102944 - ((p * t2) >> 16);
        s  = ((p * t) >> 16) >> 1;
        if (s > 32767) s = 32767;
        return int'(s);
    endfunction

    function automatic longint lfo_value(logic [31:0] phase);
        longint unsigned idx;
        idx = (longint'(phase) * SINE_N) >> 32;
        return sine_lut[idx];
    endfunction

    task automatic reset_shadow();
        longint unsigned a, t;
        int q, v;
        for (int i = 0; i < SINE_N; i++) begin
            a = (longint'(i) << 18) / SINE_N;
            q = int'(a >> 16) & 3;
            t = a & 64'hFFFF;
            if (q & 1) t = 65536 - t;
            v = quarter_wave(t);
            sine_lut[i] = (q >= 2) ? -v : v;
        end
        for (int i = 0; i < DEPTH; i++) begin
            line_l[i] = 0;
            line_r[i] = 0;
        end
        {sh_phaser_step, sh_flange_step, sh_phaser_phase, sh_flange_phase} = '0;
        {sh_phaser_depth, sh_echo_delay, sh_feedback, sh_mix, sh_flange_depth} = '0;
        sh_wr_idx = '0;
    endtask

    // Computes the output pair for one input pair and advances the shadow state.
    task automatic predict_pair(t_smp l_in, t_smp r_in);
        longint dry[2], w[2], s, ph, gain, fb, mx, off, del;
        int rd, wi;
        dry[0] = l_in;
        dry[1] = r_in;
        wi = int'(sh_wr_idx);

        sh_phaser_phase = sh_phaser_phase + sh_phaser_step;
        s    = lfo_value(sh_phaser_phase);
        ph   = 32768 + fl_shr(longint'(sh_phaser_depth) * s, 16);
        gain = 65536 - fl_shr(ph * 13107, 16);
        for (int c = 0; c < 2; c++) w[c] = clip24(fl_shr(dry[c] * gain, 16));

        sh_flange_phase = sh_flange_phase + sh_flange_step;
        s   = lfo_value(sh_flange_phase);
        off = ((longint'(sh_flange_depth) * (32768 + s)) >>> 15) + 1;
        if (off > DEPTH - 1) off = DEPTH - 1;
        rd = int'((wi + DEPTH - off) % DEPTH);
        w[0] = clip24(fl_shr(w[0] + line_l[rd], 1));
        w[1] = clip24(fl_shr(w[1] + line_r[rd], 1));
        line_l[wi] = int'(w[0]);
        line_r[wi] = int'(w[1]);

        fb  = sh_feedback;
        del = sh_echo_delay;
        if (del >= DEPTH) del = DEPTH - 1;
        rd = int'((wi + DEPTH - del) % DEPTH);
        w[0] = clip24(fl_shr(w[0] * (65536 - fb) + longint'(line_l[rd]) * fb, 16));
        w[1] = clip24(fl_shr(w[1] * (65536 - fb) + longint'(line_r[rd]) * fb, 16));
        line_l[wi] = int'(clip24(longint'(line_l[wi]) + fl_shr(w[0] * fb, 16)));
        line_r[wi] = int'(clip24(longint'(line_r[wi]) + fl_shr(w[1] * fb, 16)));
        sh_wr_idx = sh_wr_idx + 1'b1;

        mx = sh_mix;
        exp_left_q.push_back(t_smp'(clip24(fl_shr(dry[0] * (65536 - mx) + w[0] * mx, 16))));
        exp_right_q.push_back(t_smp'(clip24(fl_shr(dry[1] * (65536 - mx) + w[1] * mx, 16))));
    endtask

    // Register write, only used while the block is idle.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PHASER_STEP:  sh_phaser_step  = val;
            CFG_PHASER_DEPTH: sh_phaser_depth = val[16:0];
            CFG_FLANGE_STEP:  sh_flange_step  = val;
            CFG_FLANGE_DEPTH: sh_flange_depth = val[9:0];
            CFG_ECHO_DELAY:   sh_echo_delay   = val[16:0];
            CFG_FEEDBACK:     sh_feedback     = val[16:0];
            CFG_MIX:          sh_mix          = val[16:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] ps, logic [31:0] pd, logic [31:0] fs,
                           logic [31:0] fd, logic [31:0] ed, logic [31:0] fb,
                           logic [31:0] mx);
        write_reg(CFG_PHASER_STEP, ps);
        write_reg(CFG_PHASER_DEPTH, pd);
        write_reg(CFG_FLANGE_STEP, fs);
        write_reg(CFG_FLANGE_DEPTH, fd);
        write_reg(CFG_ECHO_DELAY, ed);
        write_reg(CFG_FEEDBACK, fb);
        write_reg(CFG_MIX, mx);
    endtask

    // Offers one stereo beat and holds it until the block takes it. The prediction
    // is made at acceptance. A random idle gap, with valid low, may follow.
    task automatic send_pair(t_smp l, t_smp r);
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pair(l, r);
        n_sent++;
        // Valid stays high if the next beat follows straight away.
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (exp_left_q.size() != 0 && guard < STALL_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_smp rand_smp();
        return t_smp'($urandom);
    endfunction

    // Receiver: random stalls and the output check.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_recv++;
            if (exp_left_q.size() == 0) begin
                $display("%0t: unexpected output beat L=%0d R=%0d", $time,
                         o_left_out, o_right_out);
                n_errors++;
            end else begin
                if (o_left_out !== exp_left_q[0]) begin
                    $display("%0t: left mismatch expected %0d actual %0d", $time,
                             exp_left_q[0], o_left_out);
                    n_errors++;
                end
                if (o_right_out !== exp_right_q[0]) begin
                    $display("%0t: right mismatch expected %0d actual %0d", $time,
                             exp_right_q[0], o_right_out);
                    n_errors++;
                end
                void'(exp_left_q.pop_front());
                void'(exp_right_q.pop_front());
            end
        end
        i_out_ready <= !hold_recv && ($urandom_range(99) >= recv_gap_pct);
    end

    // Watchdog on cycles with no beat moving on either side and no register write.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        t_smp ext[4];
        ext = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF};
        // Pass-through of extremes with everything at zero.
        foreach (ext[i]) send_pair(ext[i], ext[3 - i]);
        drain();
        // Full-depth phaser, wide flanger sweep, zero echo tap (reads the slot
        // the flanger has just written), fully wet.
        set_all(32'h0400_0000, 32'd65536, 32'h0100_0000, 32'd1023, 32'd0, 32'd65536,
                32'd65536);
        foreach (ext[i]) send_pair(ext[i], ext[i]);
        drain();
        // Gains above one and the longest echo tap, one less than the memory depth.
        set_all(32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'd1023, 32'h0001_FFFF,
                32'h0001_FFFF, 32'h0001_FFFF);
        repeat (8) send_pair(24'sh7FFFFF, 24'sh800000);
        drain();
        // Out-of-range register index must be ignored.
        write_reg(CFG_BAD_IDX, 32'hFFFF_FFFF);
        repeat (4) send_pair(rand_smp(), rand_smp());
        drain();
    endtask

    task automatic test_random(int n_items, int sgap, int rgap);
        send_gap_pct = sgap;
        recv_gap_pct = rgap;
        set_all($urandom, $urandom_range(65536 + 100), $urandom,
                $urandom_range(1023), $urandom_range(300), $urandom_range(70000),
                $urandom_range(70000));
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 49) begin
                drain();
                set_all($urandom, $urandom_range(131071), $urandom,
                        $urandom_range(1023), $urandom_range(131071),
                        $urandom_range(131071), $urandom_range(131071));
            end
            send_pair(rand_smp(), rand_smp());
        end
        drain();
    endtask

    // Receiver stops for a long while so the block backs up and stalls its input.
    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        fork
            begin
                hold_recv = 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            repeat (30) send_pair(rand_smp(), rand_smp());
        join
        drain();
    endtask

    initial begin
        reset_shadow();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300, 10, 84);
        test_random(300, 84, 10);
        test_random(300, 0, 0);
        test_backpressure();
        $display("Sent %0d stereo beats, checked %0d, across directed extremes, random",
                 n_sent, n_recv);
        $display("settings with stalls on both sides, and a long output hold-off.");
        if (n_errors == 0 && exp_left_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/spf_pkg.sv
hdl/spf_ram.sv
hdl/spf_mul.sv
hdl/stereo_phaser_flanger_delay.sv
hdl/spf_checker.sv
tb/sv/tb_top.sv
